@@ rtl/core/cwp_pkg.sv @@
// ---------------------------------------------------------------------------
// cwp_pkg: shared types and constants of the collinear waypoint pruner
// Field widths, path position codes, register indexes and the control
// structs that travel between the pruner modules.
// ---------------------------------------------------------------------------
package cwp_pkg;

  localparam int HEAD_W     = 13;
  localparam int PTOL_W     = 16;
  localparam int HTOL_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_LAT   = 8;
  localparam int OUT_DEPTH  = 4;

  localparam logic [PTOL_W-1:0] GOAL_PTOL_RST = 16'd50;
  localparam logic [HTOL_W-1:0] GOAL_HTOL_RST = 12'd35;

  // position of a word within its path
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_INNER  = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GOAL_VALID   = 2'd0,
    CFG_GOAL_HEADING = 2'd1,
    CFG_GOAL_PTOL    = 2'd2,
    CFG_GOAL_HTOL    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic   vld;
    phase_t phase;
    logic   fin;
  } ctl_t;

  localparam ctl_t CTL_IDLE = '{vld: 1'b0, phase: PH_FIRST, fin: 1'b0};

  typedef struct packed {
    logic                     valid;
    logic signed [HEAD_W-1:0] heading;
    logic [PTOL_W-1:0]        ptol;
    logic [HTOL_W-1:0]        htol;
  } goal_t;

  typedef struct packed {
    logic wr0;
    logic wr1;
  } push_t;

endpackage

@@ rtl/core/collinear_waypoint_pruner_top.sv @@
// ---------------------------------------------------------------------------
// Path: input register, 8-stage step divider with payload delay line, decision
// stage and result queue; an inner waypoint waits until its successor arrives.
// Throughput: one input word per cycle while the 4-word result queue, which
// takes two words at a path end, has room for two; otherwise in_ready is low.
// Reset: synchronous active-low rst_n clears control and queue and loads the
// goal reset values; the block starts awaiting the first waypoint of a path.
// ---------------------------------------------------------------------------
// collinear_waypoint_pruner_top: collinear waypoint pruner
// Input register, step pipeline with payload delay line, decision stage
// and result queue.
// ---------------------------------------------------------------------------
module collinear_waypoint_pruner_top #(
  parameter int COORD_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_BITS-1:0]         in_pos_x,
  input  logic signed [COORD_BITS-1:0]         in_pos_y,
  input  logic signed [COORD_BITS-1:0]         in_pos_z,
  input  logic signed [cwp_pkg::HEAD_W-1:0]    in_way_heading,
  input  logic [cwp_pkg::PTOL_W-1:0]           in_way_pos_tol,
  input  logic [cwp_pkg::HTOL_W-1:0]           in_way_heading_tol,
  input  logic                                 in_path_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [COORD_BITS-1:0]         out_x,
  output logic signed [COORD_BITS-1:0]         out_y,
  output logic signed [COORD_BITS-1:0]         out_z,
  output logic signed [cwp_pkg::HEAD_W-1:0]    out_heading,
  output logic [cwp_pkg::PTOL_W-1:0]           out_pos_tol,
  output logic [cwp_pkg::HTOL_W-1:0]           out_heading_tol,
  output logic                                 out_end,
  input  logic                                 cfg_we,
  input  logic [cwp_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [cwp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int LAT   = cwp_pkg::STEP_LAT;
  localparam int RES_W = 3*COORD_BITS + cwp_pkg::HEAD_W + cwp_pkg::PTOL_W
                         + cwp_pkg::HTOL_W + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]      x;
    logic signed [COORD_BITS-1:0]      y;
    logic signed [COORD_BITS-1:0]      z;
    logic signed [cwp_pkg::HEAD_W-1:0] head;
    logic [cwp_pkg::PTOL_W-1:0]        ptol;
    logic [cwp_pkg::HTOL_W-1:0]        htol;
  } item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]      x;
    logic signed [COORD_BITS-1:0]      y;
    logic signed [COORD_BITS-1:0]      z;
    logic signed [cwp_pkg::HEAD_W-1:0] head;
    logic [cwp_pkg::PTOL_W-1:0]        ptol;
    logic [cwp_pkg::HTOL_W-1:0]        htol;
    logic                              fin;
  } res_t;

  cwp_pkg::goal_t  goal_r;
  cwp_pkg::phase_t phase_r, phase_nxt;
  cwp_pkg::ctl_t   s0_ctl_r;
  cwp_pkg::ctl_t   dctl_r [LAT];
  item_t           s0_r;
  item_t           dl_r [LAT];
  logic signed [COORD_BITS-1:0] last_x_r, last_y_r, s0_px_r, s0_py_r;
  logic signed [COORD_BITS-3:0] step_x, step_y;

  cwp_pkg::push_t  push;
  logic [RES_W-1:0] res0, res1, fifo_q;
  res_t            out_w;
  logic            adv, acc, room;

  assign adv      = room;
  assign in_ready = adv;
  assign acc      = in_valid & in_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r <= '{valid: 1'b0, heading: '0, ptol: cwp_pkg::GOAL_PTOL_RST,
                  htol: cwp_pkg::GOAL_HTOL_RST};
    end else if (cfg_we) begin
      unique case (cwp_pkg::cfg_idx_t'(cfg_idx))
        cwp_pkg::CFG_GOAL_VALID:   goal_r.valid   <= cfg_wdata[0];
        cwp_pkg::CFG_GOAL_HEADING: goal_r.heading <= cfg_wdata[cwp_pkg::HEAD_W-1:0];
        cwp_pkg::CFG_GOAL_PTOL:    goal_r.ptol    <= cfg_wdata[cwp_pkg::PTOL_W-1:0];
        cwp_pkg::CFG_GOAL_HTOL:    goal_r.htol    <= cfg_wdata[cwp_pkg::HTOL_W-1:0];
        default: ;
      endcase
    end
  end

  // path position tracking
  always_comb begin
    unique case (phase_r) inside
      cwp_pkg::PH_SECOND, cwp_pkg::PH_INNER: phase_nxt = cwp_pkg::PH_INNER;
      default:                               phase_nxt = cwp_pkg::PH_SECOND;
    endcase
    if (in_path_end) begin
      phase_nxt = cwp_pkg::PH_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= cwp_pkg::PH_FIRST;
      s0_ctl_r <= cwp_pkg::CTL_IDLE;
      for (int i = 0; i < LAT; i++) begin
        dctl_r[i] <= cwp_pkg::CTL_IDLE;
      end
    end else begin
      if (acc) begin
        phase_r <= phase_nxt;
      end
      if (adv) begin
        s0_ctl_r <= '{vld: acc, phase: phase_r, fin: in_path_end};
        dctl_r[0] <= s0_ctl_r;
        for (int i = 1; i < LAT; i++) begin
          dctl_r[i] <= dctl_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s0_r     <= '{x: in_pos_x, y: in_pos_y, z: in_pos_z, head: in_way_heading,
                    ptol: in_way_pos_tol, htol: in_way_heading_tol};
      s0_px_r  <= last_x_r;
      s0_py_r  <= last_y_r;
      last_x_r <= in_pos_x;
      last_y_r <= in_pos_y;
    end
    if (adv) begin
      dl_r[0] <= s0_r;
      for (int i = 1; i < LAT; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  cwp_step_unit #(.COORD_BITS(COORD_BITS)) u_step_x (
    .clk  (clk),
    .en   (adv),
    .cur  (s0_r.x),
    .prev (s0_px_r),
    .step (step_x)
  );

  cwp_step_unit #(.COORD_BITS(COORD_BITS)) u_step_y (
    .clk  (clk),
    .en   (adv),
    .cur  (s0_r.y),
    .prev (s0_py_r),
    .step (step_y)
  );

  cwp_tail #(.COORD_BITS(COORD_BITS)) u_tail (
    .clk    (clk),
    .en     (adv),
    .ctl    (dctl_r[LAT-1]),
    .goal   (goal_r),
    .x      (dl_r[LAT-1].x),
    .y      (dl_r[LAT-1].y),
    .z      (dl_r[LAT-1].z),
    .head   (dl_r[LAT-1].head),
    .ptol   (dl_r[LAT-1].ptol),
    .htol   (dl_r[LAT-1].htol),
    .step_x (step_x),
    .step_y (step_y),
    .push   (push),
    .res0   (res0),
    .res1   (res1)
  );

  cwp_out_fifo #(.W(RES_W), .DEPTH(cwp_pkg::OUT_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .d0        (res0),
    .d1        (res1),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .q         (fifo_q),
    .room      (room)
  );

  assign out_w           = fifo_q;
  assign out_x           = out_w.x;
  assign out_y           = out_w.y;
  assign out_z           = out_w.z;
  assign out_heading     = out_w.head;
  assign out_pos_tol     = out_w.ptol;
  assign out_heading_tol = out_w.htol;
  assign out_end         = out_w.fin;

  ap_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.wr1 |-> push.wr0)
    else $error("second result word pushed without first");

  ap_push_src: assert property (@(posedge clk) disable iff (!rst_n)
    push.wr0 |-> (adv && dctl_r[LAT-1].vld))
    else $error("result pushed without a valid word in the last stage");

  ap_push_out: assert property (@(posedge clk) disable iff (!rst_n)
    push.wr0 |=> out_valid)
    else $error("pushed result not visible at output");

  ap_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_path_end) |=> (phase_r == cwp_pkg::PH_FIRST))
    else $error("path end did not restart path tracking");

endmodule

@@ rtl/core/cwp_step_unit.sv @@
// ---------------------------------------------------------------------------
// cwp_step_unit: pipelined millimetre-to-centimetre step
// Difference of two coordinates divided by ten, rounded half away from
// zero. Eight stages, reciprocal by shift-add with a small remainder fix.
// ---------------------------------------------------------------------------
module cwp_step_unit #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] cur,
  input  logic signed [COORD_BITS-1:0] prev,
  output logic signed [COORD_BITS-3:0] step
);

  localparam int DW = COORD_BITS + 1;
  localparam int SW = COORD_BITS - 2;

  logic [DW-1:0] d1_r;
  logic [DW-1:0] n2_r, n3_r, n4_r, n5_r, n6_r;
  logic          neg2_r, neg3_r, neg4_r, neg5_r, neg6_r, neg7_r;
  logic [DW-1:0] qa_r, qb_r, qc_r, qd_r, qe_r;
  logic [1:0]    adj7_r;
  logic [SW-1:0] step8_r;

  logic [DW-1:0] d1_nxt, n2_nxt, qa_nxt, qb_nxt, qc_nxt, qd_nxt, qe_nxt;
  logic [5:0]    t10, rem;
  logic [1:0]    adj7_nxt;
  logic [DW-1:0] op, kk, sum;

  always_comb begin
    d1_nxt = {cur[COORD_BITS-1], cur} - {prev[COORD_BITS-1], prev};
    n2_nxt = d1_r[DW-1] ? (DW'(5) - d1_r) : (d1_r + DW'(5));
    qa_nxt = (n2_r >> 1) + (n2_r >> 2);
    qb_nxt = qa_r + (qa_r >> 4);
    qc_nxt = qb_r + (qb_r >> 8);
    qd_nxt = qc_r + (qc_r >> 16);
    qe_nxt = qd_r >> 3;
    // remainder is small, low six bits suffice
    t10 = {qe_nxt[2:0], 3'b000} + {qe_nxt[4:0], 1'b0};
    rem = n6_r[5:0] - t10;
    if (rem >= 6'd30) begin
      adj7_nxt = 2'd3;
    end else if (rem >= 6'd20) begin
      adj7_nxt = 2'd2;
    end else if (rem >= 6'd10) begin
      adj7_nxt = 2'd1;
    end else begin
      adj7_nxt = 2'd0;
    end
    // negative: ~q + 1 - adj = -(q + adj)
    op  = neg7_r ? ~qe_r : qe_r;
    kk  = neg7_r ? (DW'(1) - DW'(adj7_r)) : DW'(adj7_r);
    sum = op + kk;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r    <= d1_nxt;
      n2_r    <= n2_nxt;
      neg2_r  <= d1_r[DW-1];
      qa_r    <= qa_nxt;
      n3_r    <= n2_r;
      neg3_r  <= neg2_r;
      qb_r    <= qb_nxt;
      n4_r    <= n3_r;
      neg4_r  <= neg3_r;
      qc_r    <= qc_nxt;
      n5_r    <= n4_r;
      neg5_r  <= neg4_r;
      qd_r    <= qd_nxt;
      n6_r    <= n5_r;
      neg6_r  <= neg5_r;
      qe_r    <= qe_nxt;
      adj7_r  <= adj7_nxt;
      neg7_r  <= neg6_r;
      step8_r <= sum[SW-1:0];
    end
  end

  assign step = step8_r;

endmodule

@@ rtl/core/cwp_tail.sv @@
// ---------------------------------------------------------------------------
// cwp_tail: keep/drop decision and held candidate
// Holds the inner candidate, compares steps into and out of it and builds
// up to two result words per incoming word, with goal override on the end.
// ---------------------------------------------------------------------------
module cwp_tail #(
  parameter int COORD_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  cwp_pkg::ctl_t                        ctl,
  input  cwp_pkg::goal_t                       goal,
  input  logic signed [COORD_BITS-1:0]         x,
  input  logic signed [COORD_BITS-1:0]         y,
  input  logic signed [COORD_BITS-1:0]         z,
  input  logic signed [cwp_pkg::HEAD_W-1:0]    head,
  input  logic [cwp_pkg::PTOL_W-1:0]           ptol,
  input  logic [cwp_pkg::HTOL_W-1:0]           htol,
  input  logic signed [COORD_BITS-3:0]         step_x,
  input  logic signed [COORD_BITS-3:0]         step_y,
  output cwp_pkg::push_t                       push,
  output logic [3*COORD_BITS+cwp_pkg::HEAD_W+cwp_pkg::PTOL_W+cwp_pkg::HTOL_W:0] res0,
  output logic [3*COORD_BITS+cwp_pkg::HEAD_W+cwp_pkg::PTOL_W+cwp_pkg::HTOL_W:0] res1
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0]      x;
    logic signed [COORD_BITS-1:0]      y;
    logic signed [COORD_BITS-1:0]      z;
    logic signed [cwp_pkg::HEAD_W-1:0] head;
    logic [cwp_pkg::PTOL_W-1:0]        ptol;
    logic [cwp_pkg::HTOL_W-1:0]        htol;
    logic                              fin;
  } res_t;

  res_t                         held_r;
  logic signed [COORD_BITS-3:0] held_sx_r, held_sy_r;

  res_t cur_w, held_w;
  logic vld, emit_held, emit_cur, hold;

  always_comb begin
    vld = en & ctl.vld;
    cur_w = '{x: x, y: y, z: z, head: head, ptol: ptol, htol: htol, fin: ctl.fin};
    if (ctl.fin && goal.valid) begin
      cur_w.head = goal.heading;
      cur_w.ptol = goal.ptol;
      cur_w.htol = goal.htol;
    end
    held_w     = held_r;
    held_w.fin = 1'b0;
    case (ctl.phase) inside
      cwp_pkg::PH_SECOND, cwp_pkg::PH_INNER: begin
        emit_held = (ctl.phase == cwp_pkg::PH_INNER) &&
                    ((step_x != held_sx_r) || (step_y != held_sy_r));
        emit_cur  = ctl.fin;
        hold      = !ctl.fin;
      end
      default: begin
        emit_held = 1'b0;
        emit_cur  = 1'b1;
        hold      = 1'b0;
      end
    endcase
    push.wr0 = vld & (emit_held | emit_cur);
    push.wr1 = vld & emit_held & emit_cur;
    res0     = emit_held ? held_w : cur_w;
    res1     = cur_w;
  end

  always_ff @(posedge clk) begin
    if (vld && hold) begin
      held_r    <= cur_w;
      held_sx_r <= step_x;
      held_sy_r <= step_y;
    end
  end

endmodule

@@ rtl/core/cwp_out_fifo.sv @@
// ---------------------------------------------------------------------------
// cwp_out_fifo: result queue
// Small register queue taking up to two words per cycle and handing one
// word per cycle to the output channel while out_ready is high.
// ---------------------------------------------------------------------------
module cwp_out_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cwp_pkg::push_t push,
  input  logic [W-1:0]   d0,
  input  logic [W-1:0]   d1,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [W-1:0]   q,
  output logic           room
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r, wptr_nxt, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  always_comb begin
    pop      = out_valid & out_ready;
    wptr_nxt = wptr_r + AW'(push.wr0) + AW'(push.wr1);
    rptr_nxt = rptr_r + AW'(pop);
    cnt_nxt  = cnt_r + CW'(push.wr0) + CW'(push.wr1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.wr0) begin
      mem_r[wptr_r] <= d0;
    end
    if (push.wr1) begin
      mem_r[wptr_r + AW'(1)] <= d1;
    end
  end

  assign out_valid = (cnt_r != '0);
  assign q         = mem_r[rptr_r];
  assign room      = (cnt_r <= CW'(DEPTH - 2));

endmodule

@@ test/collinear_waypoint_pruner_top_tb.sv @@
// ---------------------------------------------------------------------------
// collinear_waypoint_pruner_top_tb: self-checking bench for the waypoint pruner
// Sends directed paths (coordinate extremes, cm rounding edges, collinear and
// bent paths, one- and two-point paths), then random paths under changing
// goal settings and handshake idling. A scoreboard predicts the kept words
// and checks every output word in order.
// ---------------------------------------------------------------------------
module collinear_waypoint_pruner_top_tb;

  localparam int CW = 24;
  localparam int HW = cwp_pkg::HEAD_W;
  localparam int PW = cwp_pkg::PTOL_W;
  localparam int TW = cwp_pkg::HTOL_W;
  localparam int DW = cwp_pkg::CFG_DATA_W;
  localparam logic signed [CW-1:0] X_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] X_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [HW-1:0] heading;
    logic [PW-1:0]        ptol;
    logic [TW-1:0]        htol;
    logic                 fin;
  } waypoint_t;

  class pruner_scoreboard;
    cwp_pkg::phase_t      state = cwp_pkg::PH_FIRST;
    logic signed [CW-1:0] last_x = '0;
    logic signed [CW-1:0] last_y = '0;
    longint               last_dx = 0;
    longint               last_dy = 0;
    waypoint_t            held = '0;
    cwp_pkg::goal_t       goal = '{valid: 1'b0, heading: '0,
                                   ptol: cwp_pkg::GOAL_PTOL_RST,
                                   htol: cwp_pkg::GOAL_HTOL_RST};
    waypoint_t            kept_q[$];
    int                   mismatches = 0;

    function int pending();
      return kept_q.size();
    endfunction

    function void set_reg(cwp_pkg::cfg_idx_t idx, logic [DW-1:0] d);
      case (idx)
        cwp_pkg::CFG_GOAL_VALID:   goal.valid = d[0];
        cwp_pkg::CFG_GOAL_HEADING: goal.heading = d[HW-1:0];
        cwp_pkg::CFG_GOAL_PTOL:    goal.ptol = d[PW-1:0];
        cwp_pkg::CFG_GOAL_HTOL:    goal.htol = d[TW-1:0];
        default: ;
      endcase
    endfunction

    // mm to cm, half away from zero
    function longint to_cm(longint d_mm);
      longint mag;
      mag = (d_mm < 0) ? -d_mm : d_mm;
      mag = (mag + 5) / 10;
      return (d_mm < 0) ? -mag : mag;
    endfunction

    function void keep(waypoint_t w, logic fin);
      if (fin && goal.valid) begin
        w.heading = goal.heading;
        w.ptol    = goal.ptol;
        w.htol    = goal.htol;
      end
      w.fin = fin;
      kept_q.insert(kept_q.size(), w);
    endfunction

    function void note_waypoint(waypoint_t w);
      longint dx, dy;
      if (state == cwp_pkg::PH_SECOND || state == cwp_pkg::PH_INNER) begin
        dx = to_cm(longint'(w.x) - longint'(last_x));
        dy = to_cm(longint'(w.y) - longint'(last_y));
        if (state == cwp_pkg::PH_INNER && (dx != last_dx || dy != last_dy))
          keep(held, 1'b0);
        if (w.fin) begin
          keep(w, 1'b1);
          state = cwp_pkg::PH_FIRST;
        end else begin
          last_dx = dx;
          last_dy = dy;
          last_x  = w.x;
          last_y  = w.y;
          held    = w;
          state   = cwp_pkg::PH_INNER;
        end
      end else begin
        keep(w, w.fin);
        if (w.fin) begin
          state = cwp_pkg::PH_FIRST;
        end else begin
          last_x = w.x;
          last_y = w.y;
          state  = cwp_pkg::PH_SECOND;
        end
      end
    endfunction

    function void check_waypoint(waypoint_t got);
      waypoint_t want;
      if (kept_q.size() == 0) begin
        $error("unexpected output word x=%0d y=%0d end=%0d", got.x, got.y, got.fin);
        mismatches++;
        return;
      end
      want = kept_q.pop_front();
      if (got.x !== want.x) begin
        $error("out_x expected %0d got %0d", want.x, got.x);
        mismatches++;
      end
      if (got.y !== want.y) begin
        $error("out_y expected %0d got %0d", want.y, got.y);
        mismatches++;
      end
      if (got.z !== want.z) begin
        $error("out_z expected %0d got %0d", want.z, got.z);
        mismatches++;
      end
      if (got.heading !== want.heading) begin
        $error("out_heading expected %0d got %0d", want.heading, got.heading);
        mismatches++;
      end
      if (got.ptol !== want.ptol) begin
        $error("out_pos_tol expected %0d got %0d", want.ptol, got.ptol);
        mismatches++;
      end
      if (got.htol !== want.htol) begin
        $error("out_heading_tol expected %0d got %0d", want.htol, got.htol);
        mismatches++;
      end
      if (got.fin !== want.fin) begin
        $error("out_end expected %0d got %0d", want.fin, got.fin);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [CW-1:0] in_pos_x;
  logic signed [CW-1:0] in_pos_y;
  logic signed [CW-1:0] in_pos_z;
  logic signed [HW-1:0] in_way_heading;
  logic [PW-1:0]        in_way_pos_tol;
  logic [TW-1:0]        in_way_heading_tol;
  logic                 in_path_end;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic signed [HW-1:0] out_heading;
  logic [PW-1:0]        out_pos_tol;
  logic [TW-1:0]        out_heading_tol;
  logic                 out_end;
  logic                 cfg_we;
  cwp_pkg::cfg_idx_t    cfg_idx;
  logic [DW-1:0]        cfg_wdata;

  pruner_scoreboard sb = new;

  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  bit          hold_req = 1'b0;
  bit          pause_req = 1'b0;
  int          words_sent = 0;

  collinear_waypoint_pruner_top #(
    .COORD_BITS(CW)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_way_heading    (in_way_heading),
    .in_way_pos_tol    (in_way_pos_tol),
    .in_way_heading_tol(in_way_heading_tol),
    .in_path_end       (in_path_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_z             (out_z),
    .out_heading       (out_heading),
    .out_pos_tol       (out_pos_tol),
    .out_heading_tol   (out_heading_tol),
    .out_end           (out_end),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    waypoint_t got;
    if (rst_n && out_valid && out_ready) begin
      got.x       = out_x;
      got.y       = out_y;
      got.z       = out_z;
      got.heading = out_heading;
      got.ptol    = out_pos_tol;
      got.htol    = out_heading_tol;
      got.fin     = out_end;
      sb.check_waypoint(got);
    end
  end

  function automatic waypoint_t mk(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                   logic signed [CW-1:0] z, logic [HW-1:0] h,
                                   logic [PW-1:0] p, logic [TW-1:0] t,
                                   logic fin);
    waypoint_t w;
    w.x       = x;
    w.y       = y;
    w.z       = z;
    w.heading = h;
    w.ptol    = p;
    w.htol    = t;
    w.fin     = fin;
    return w;
  endfunction

  function automatic waypoint_t pt(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                   logic fin);
    return mk(x, y, CW'($urandom), HW'($urandom), PW'($urandom), TW'($urandom), fin);
  endfunction

  function automatic int rand_step();
    if ($urandom_range(3) == 0)
      return 10 * (int'($urandom_range(400000)) - 200000);
    return 10 * (int'($urandom_range(100)) - 50);
  endfunction

  // stays within one cm bucket
  function automatic int jitter();
    return int'($urandom_range(8)) - 4;
  endfunction

  task automatic push_word(waypoint_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_pos_x           <= w.x;
    in_pos_y           <= w.y;
    in_pos_z           <= w.z;
    in_way_heading     <= w.heading;
    in_way_pos_tol     <= w.ptol;
    in_way_heading_tol <= w.htol;
    in_path_end        <= w.fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_waypoint(w);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * cwp_pkg::STEP_LAT + 4) @(posedge clk);
  endtask

  task automatic write_goal(logic v, logic signed [HW-1:0] h, logic [PW-1:0] p,
                            logic [TW-1:0] t);
    cwp_pkg::cfg_idx_t regs[4];
    logic [DW-1:0]     vals[4];
    regs    = '{cwp_pkg::CFG_GOAL_VALID, cwp_pkg::CFG_GOAL_HEADING,
                cwp_pkg::CFG_GOAL_PTOL, cwp_pkg::CFG_GOAL_HTOL};
    vals[0] = DW'($urandom);
    vals[0][0] = v;
    vals[1] = DW'(h);
    vals[2] = p;
    vals[3] = DW'(t);
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= regs[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
      sb.set_reg(regs[k], vals[k]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_path();
    int unsigned          len, r;
    bit                   noise;
    logic signed [CW-1:0] px, py;
    int                   sx, sy;
    r = $urandom_range(99);
    if (r < 10)
      len = $urandom_range(2, 1);
    else if (r < 85)
      len = $urandom_range(10, 3);
    else
      len = $urandom_range(40, 11);
    noise = ($urandom_range(9) == 0);
    px = CW'($urandom);
    py = CW'($urandom);
    sx = rand_step();
    sy = rand_step();
    for (int unsigned i = 0; i < len; i++) begin
      if (pause_req && i == 2) begin
        pause_req = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      if (i > 0) begin
        if (noise) begin
          px = CW'($urandom);
          py = CW'($urandom);
        end else begin
          r = $urandom_range(99);
          if (r < 15) begin
            sx = rand_step();
            sy = rand_step();
          end else if (r < 25) begin
            sx = 0;
            sy = 0;
          end else if (r < 40) begin
            sx += 10 * (int'($urandom_range(2)) - 1);
            sy += 10 * (int'($urandom_range(2)) - 1);
          end
          px = CW'(px + sx + jitter());
          py = CW'(py + sy + jitter());
        end
      end
      push_word(mk(px, py, CW'($urandom), HW'($urandom), PW'($urandom), TW'($urandom),
                   i == len - 1));
    end
  endtask

  initial begin
    int unsigned idle_send[4];
    int unsigned idle_recv[4];
    int          base;
    bit          hold_done;
    idle_send = '{0, 67, 0, 18};
    idle_recv = '{0, 0, 67, 18};
    hold_done = 1'b0;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_pos_x           = '0;
    in_pos_y           = '0;
    in_pos_z           = '0;
    in_way_heading     = '0;
    in_way_pos_tol     = '0;
    in_way_heading_tol = '0;
    in_path_end        = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = cwp_pkg::CFG_GOAL_VALID;
    cfg_wdata          = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // single-point paths at the field extremes
    push_word(mk(X_MAX, X_MIN, X_MAX, 13'h0FFF, 16'hFFFF, 12'hFFF, 1'b1));
    push_word(mk(X_MIN, X_MAX, X_MIN, 13'h1000, 16'h0000, 12'h000, 1'b1));
    // two points pass through
    push_word(pt(0, 0, 1'b0));
    push_word(pt(100, 100, 1'b1));
    // straight line, middle point dropped
    push_word(pt(0, 0, 1'b0));
    push_word(pt(100, 0, 1'b0));
    push_word(pt(200, 0, 1'b1));
    // rounding edges: +5, +5, +4, -5, -4, zero step
    push_word(pt(0, 0, 1'b0));
    push_word(pt(5, 0, 1'b0));
    push_word(pt(10, 0, 1'b0));
    push_word(pt(14, 0, 1'b0));
    push_word(pt(9, 0, 1'b0));
    push_word(pt(5, 0, 1'b0));
    push_word(pt(5, 0, 1'b0));
    push_word(pt(5, -5, 1'b1));
    // full-scale jumps
    push_word(pt(X_MIN, X_MIN, 1'b0));
    push_word(pt(X_MAX, X_MAX, 1'b0));
    push_word(pt(X_MIN, X_MAX, 1'b1));

    // goal pose with zero tolerances on the final word
    wait_idle();
    write_goal(1'b1, -13'sd3142, '0, '0);
    push_word(pt(7, 7, 1'b1));
    push_word(pt(0, 0, 1'b0));
    push_word(pt(-30, 40, 1'b1));

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph % 4)
        0:       write_goal(1'b1, 13'sd3142, 16'hFFFF, 12'hFFF);
        1:       write_goal(1'b0, HW'($urandom), PW'($urandom), TW'($urandom));
        2:       write_goal(1'b1, -13'sd3142, '0, '0);
        default: write_goal(1'b1, HW'($urandom), PW'($urandom), TW'($urandom));
      endcase
      send_idle  = idle_send[ph % 4];
      recv_stall = idle_recv[ph % 4];
      pause_req  = (ph == 5);
      base = words_sent;
      while (words_sent < base + 100) begin
        if (ph == 0 && !hold_done && words_sent >= base + 30) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        send_random_path();
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cwp_pkg.sv
rtl/core/cwp_step_unit.sv
rtl/core/cwp_tail.sv
rtl/core/cwp_out_fifo.sv
rtl/core/collinear_waypoint_pruner_top.sv
test/collinear_waypoint_pruner_top_tb.sv
